// ===== rtl/mtq_pkg.sv =====
`timescale 1ns / 1ps

package mtq_pkg;

    localparam int ELEM_W     = 32;
    localparam int RAD_W      = 34;
    localparam int PAIR_W     = 33;
    localparam int ROOT_W     = 31;
    localparam int SQ_REM_W   = 35;
    localparam int SQ_STAGES  = ROOT_W;
    localparam int NUM_W      = 61;
    localparam int DEN_W      = 32;
    localparam int QUOT_W     = 32;
    localparam int DIV_REM_W  = 33;
    localparam int DIV_STAGES = QUOT_W;
    localparam int FRAC_BITS  = 28;
    localparam int LATENCY    = 1 + 2 + SQ_STAGES + 1 + DIV_STAGES + 1;

    localparam logic [1:0] IDX_X = 2'd0;
    localparam logic [1:0] IDX_Y = 2'd1;
    localparam logic [1:0] IDX_Z = 2'd2;
    localparam logic [1:0] IDX_W = 2'd3;

    localparam logic signed [ELEM_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ELEM_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [ELEM_W-1:0] row0_col0;
        logic signed [ELEM_W-1:0] row0_col1;
        logic signed [ELEM_W-1:0] row0_col2;
        logic signed [ELEM_W-1:0] row1_col0;
        logic signed [ELEM_W-1:0] row1_col1;
        logic signed [ELEM_W-1:0] row1_col2;
        logic signed [ELEM_W-1:0] row2_col0;
        logic signed [ELEM_W-1:0] row2_col1;
        logic signed [ELEM_W-1:0] row2_col2;
    } mat_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] quat_x;
        logic signed [ELEM_W-1:0] quat_y;
        logic signed [ELEM_W-1:0] quat_z;
        logic signed [ELEM_W-1:0] quat_w;
        logic                     bad_input;
    } quat_t;

    typedef struct packed {
        logic signed [PAIR_W-1:0] pa;
        logic signed [PAIR_W-1:0] pb;
        logic signed [PAIR_W-1:0] pc;
        logic [1:0]               main_idx;
        logic                     bad;
    } side_t;

    typedef struct packed {
        logic neg;
        logic ovf;
    } dtag_t;

endpackage

// ===== rtl/matrix_to_quaternion.sv =====
`timescale 1ns / 1ps

// Rotation matrix to quaternion converter, Shepperd branch selection, signed
// Q3.28 in and out. The block never stalls: busy is always low and a new
// transaction is taken on every clock with start high. Each result appears
// on quat for exactly one cycle with done high, in input order; the
// receiver cannot hold it off. The result passes through the 31-stage
// square root pipeline and the 32-stage divider pipelines (one quotient
// bit per stage). A not-positive radicand gives zero components with
// bad_input set.
module matrix_to_quaternion (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  mtq_pkg::mat_t   matrix,
    output logic            done,
    output mtq_pkg::quat_t  quat
);

    localparam int ND = mtq_pkg::DIV_STAGES;

    logic                         in_valid_reg;
    mtq_pkg::mat_t                in_mat_reg;

    logic                         f_valid;
    logic [mtq_pkg::RAD_W-1:0]    f_rad;
    mtq_pkg::side_t               f_side;

    logic                         s_valid;
    logic [mtq_pkg::ROOT_W-1:0]   s_root;
    mtq_pkg::side_t               s_side;

    logic [mtq_pkg::DEN_W-1:0]    den_next;
    logic [mtq_pkg::DEN_W-1:0]    rem_next  [0:2];
    logic [mtq_pkg::QUOT_W-1:0]   lo_next   [0:2];
    mtq_pkg::dtag_t               tag_next  [0:2];
    logic signed [mtq_pkg::PAIR_W-1:0] pv   [0:2];

    logic                         p_valid_reg;
    logic [mtq_pkg::DEN_W-1:0]    p_den_reg;
    logic [mtq_pkg::DEN_W-1:0]    p_rem_reg [0:2];
    logic [mtq_pkg::QUOT_W-1:0]   p_lo_reg  [0:2];
    mtq_pkg::dtag_t               p_tag_reg [0:2];

    logic [ND:1]                  d_valid_reg;
    logic [1:0]                   d_idx_reg  [0:ND];
    logic                         d_bad_reg  [0:ND];
    logic [mtq_pkg::ROOT_W-1:0]   d_half_reg [0:ND];
    logic [mtq_pkg::ROOT_W-1:0]   half_next;

    logic [mtq_pkg::QUOT_W-1:0]   dq   [0:2];
    mtq_pkg::dtag_t               dtag [0:2];
    logic signed [mtq_pkg::ELEM_W-1:0] cv [0:2];
    logic signed [mtq_pkg::ELEM_W-1:0] hv;

    logic                         done_reg;
    mtq_pkg::quat_t               quat_reg;
    mtq_pkg::quat_t               quat_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        in_mat_reg <= matrix;
    end

    mtq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .mat       (in_mat_reg),
        .out_valid (f_valid),
        .rad       (f_rad),
        .side      (f_side)
    );

    mtq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .rad       (f_rad),
        .in_side   (f_side),
        .out_valid (s_valid),
        .root      (s_root),
        .out_side  (s_side)
    );

    // numerator |p| * 2^28 + s over divisor 2s gives the rounded quotient
    assign den_next  = {s_root, 1'b0};
    assign half_next = mtq_pkg::ROOT_W'(({1'b0, s_root} + 1'b1) >> 1);
    assign pv[0] = s_side.pa;
    assign pv[1] = s_side.pb;
    assign pv[2] = s_side.pc;

    for (genvar j = 0; j < 3; j++)
    begin : g_prep
        logic [mtq_pkg::PAIR_W-1:0] mag;
        logic [mtq_pkg::NUM_W-1:0]  num;

        assign mag = pv[j][mtq_pkg::PAIR_W-1] ? mtq_pkg::PAIR_W'(-pv[j]) : pv[j];
        assign num = {mag[mtq_pkg::NUM_W-mtq_pkg::FRAC_BITS-1:0], {mtq_pkg::FRAC_BITS{1'b0}}}
                   + mtq_pkg::NUM_W'(s_root);
        assign rem_next[j] = mtq_pkg::DEN_W'(num[mtq_pkg::NUM_W-1:mtq_pkg::QUOT_W]);
        assign lo_next[j]  = num[mtq_pkg::QUOT_W-1:0];
        assign tag_next[j].neg = pv[j][mtq_pkg::PAIR_W-1];
        assign tag_next[j].ovf = (rem_next[j] >= den_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            d_valid_reg <= '0;
        end
        else
        begin
            p_valid_reg <= s_valid;
            d_valid_reg <= {d_valid_reg[ND-1:1], p_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        p_den_reg <= den_next;
        for (int j = 0; j < 3; j++)
        begin
            p_rem_reg[j] <= rem_next[j];
            p_lo_reg[j]  <= lo_next[j];
            p_tag_reg[j] <= tag_next[j];
        end
        d_idx_reg[0]  <= s_side.main_idx;
        d_bad_reg[0]  <= s_side.bad;
        d_half_reg[0] <= half_next;
        for (int k = 1; k <= ND; k++)
        begin
            d_idx_reg[k]  <= d_idx_reg[k-1];
            d_bad_reg[k]  <= d_bad_reg[k-1];
            d_half_reg[k] <= d_half_reg[k-1];
        end
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_div
        mtq_div u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (p_valid_reg),
            .rem_init (p_rem_reg[j]),
            .num_lo   (p_lo_reg[j]),
            .den      (p_den_reg),
            .in_tag   (p_tag_reg[j]),
            .quot     (dq[j]),
            .out_tag  (dtag[j])
        );

        always_comb
        begin
            if (!dtag[j].neg)
            begin
                if (dtag[j].ovf || dq[j][mtq_pkg::QUOT_W-1])
                    cv[j] = mtq_pkg::Q_MAX;
                else
                    cv[j] = dq[j];
            end
            else
            begin
                if (dtag[j].ovf || (dq[j] > mtq_pkg::Q_MIN))
                    cv[j] = mtq_pkg::Q_MIN;
                else
                    cv[j] = -dq[j];
            end
        end
    end

    assign hv = mtq_pkg::ELEM_W'(d_half_reg[ND]);

    always_comb
    begin
        quat_next.bad_input = 1'b0;
        unique case (d_idx_reg[ND])
            mtq_pkg::IDX_X:
            begin
                quat_next.quat_x = hv;
                quat_next.quat_y = cv[0];
                quat_next.quat_z = cv[1];
                quat_next.quat_w = cv[2];
            end
            mtq_pkg::IDX_Y:
            begin
                quat_next.quat_x = cv[0];
                quat_next.quat_y = hv;
                quat_next.quat_z = cv[1];
                quat_next.quat_w = cv[2];
            end
            mtq_pkg::IDX_Z:
            begin
                quat_next.quat_x = cv[0];
                quat_next.quat_y = cv[1];
                quat_next.quat_z = hv;
                quat_next.quat_w = cv[2];
            end
            default:
            begin
                quat_next.quat_x = cv[0];
                quat_next.quat_y = cv[1];
                quat_next.quat_z = cv[2];
                quat_next.quat_w = hv;
            end
        endcase
        if (d_bad_reg[ND])
        begin
            quat_next = '0;
            quat_next.bad_input = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid_reg[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        quat_reg <= quat_next;
    end

    assign done = done_reg;
    assign quat = quat_reg;

    property p_latency;
        @(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##68 done;
    endproperty
    a_latency: assert property (p_latency)
        else $error("result did not arrive at fixed latency");

    property p_bad_zero;
        @(posedge clk) disable iff (!rst_n)
        done && quat.bad_input |-> (quat.quat_x == 0) && (quat.quat_y == 0)
                                   && (quat.quat_z == 0) && (quat.quat_w == 0);
    endproperty
    a_bad_zero: assert property (p_bad_zero)
        else $error("bad input transaction with nonzero components");

    property p_main_nonzero;
        @(posedge clk) disable iff (!rst_n)
        d_valid_reg[ND] && !d_bad_reg[ND] |-> (d_half_reg[ND] != 0);
    endproperty
    a_main_nonzero: assert property (p_main_nonzero)
        else $error("main component zero on a positive radicand");

endmodule

// ===== rtl/mtq_front.sv =====
`timescale 1ns / 1ps

module mtq_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  mtq_pkg::mat_t                    mat,
    output logic                             out_valid,
    output logic [mtq_pkg::RAD_W-1:0]        rad,
    output mtq_pkg::side_t                   side
);

    logic                          a_valid_reg;
    mtq_pkg::mat_t                 a_mat_reg;
    logic signed [mtq_pkg::RAD_W-1:0] a_trace_reg;
    logic                          a_ge01_reg;
    logic                          a_ge02_reg;
    logic                          a_ge12_reg;

    logic signed [mtq_pkg::RAD_W-1:0] trace_next;
    logic signed [mtq_pkg::RAD_W:0]   rad_s;
    logic signed [mtq_pkg::RAD_W:0]   d00, d11, d22, one_q;
    mtq_pkg::side_t                side_next;

    logic                          b_valid_reg;
    logic [mtq_pkg::RAD_W-1:0]     b_rad_reg;
    mtq_pkg::side_t                b_side_reg;

    assign trace_next = mtq_pkg::RAD_W'(mat.row0_col0) + mtq_pkg::RAD_W'(mat.row1_col1)
                      + mtq_pkg::RAD_W'(mat.row2_col2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_mat_reg   <= mat;
        a_trace_reg <= trace_next;
        a_ge01_reg  <= (mat.row0_col0 >= mat.row1_col1);
        a_ge02_reg  <= (mat.row0_col0 >= mat.row2_col2);
        a_ge12_reg  <= (mat.row1_col1 >= mat.row2_col2);
    end

    assign d00   = (mtq_pkg::RAD_W+1)'(a_mat_reg.row0_col0);
    assign d11   = (mtq_pkg::RAD_W+1)'(a_mat_reg.row1_col1);
    assign d22   = (mtq_pkg::RAD_W+1)'(a_mat_reg.row2_col2);
    assign one_q = (mtq_pkg::RAD_W+1)'(1) <<< mtq_pkg::FRAC_BITS;

    always_comb
    begin
        if (a_trace_reg >= 0)
        begin
            side_next.main_idx = mtq_pkg::IDX_W;
            rad_s = (mtq_pkg::RAD_W+1)'(a_trace_reg) + one_q;
            side_next.pa = mtq_pkg::PAIR_W'(a_mat_reg.row2_col1) - mtq_pkg::PAIR_W'(a_mat_reg.row1_col2);
            side_next.pb = mtq_pkg::PAIR_W'(a_mat_reg.row0_col2) - mtq_pkg::PAIR_W'(a_mat_reg.row2_col0);
            side_next.pc = mtq_pkg::PAIR_W'(a_mat_reg.row1_col0) - mtq_pkg::PAIR_W'(a_mat_reg.row0_col1);
        end
        else if (a_ge01_reg && a_ge02_reg)
        begin
            side_next.main_idx = mtq_pkg::IDX_X;
            rad_s = d00 - (d11 + d22) + one_q;
            side_next.pa = mtq_pkg::PAIR_W'(a_mat_reg.row0_col1) + mtq_pkg::PAIR_W'(a_mat_reg.row1_col0);
            side_next.pb = mtq_pkg::PAIR_W'(a_mat_reg.row0_col2) + mtq_pkg::PAIR_W'(a_mat_reg.row2_col0);
            side_next.pc = mtq_pkg::PAIR_W'(a_mat_reg.row2_col1) - mtq_pkg::PAIR_W'(a_mat_reg.row1_col2);
        end
        else if (a_ge12_reg)
        begin
            side_next.main_idx = mtq_pkg::IDX_Y;
            rad_s = d11 - (d22 + d00) + one_q;
            side_next.pa = mtq_pkg::PAIR_W'(a_mat_reg.row0_col1) + mtq_pkg::PAIR_W'(a_mat_reg.row1_col0);
            side_next.pb = mtq_pkg::PAIR_W'(a_mat_reg.row1_col2) + mtq_pkg::PAIR_W'(a_mat_reg.row2_col1);
            side_next.pc = mtq_pkg::PAIR_W'(a_mat_reg.row0_col2) - mtq_pkg::PAIR_W'(a_mat_reg.row2_col0);
        end
        else
        begin
            side_next.main_idx = mtq_pkg::IDX_Z;
            rad_s = d22 - (d00 + d11) + one_q;
            side_next.pa = mtq_pkg::PAIR_W'(a_mat_reg.row0_col2) + mtq_pkg::PAIR_W'(a_mat_reg.row2_col0);
            side_next.pb = mtq_pkg::PAIR_W'(a_mat_reg.row1_col2) + mtq_pkg::PAIR_W'(a_mat_reg.row2_col1);
            side_next.pc = mtq_pkg::PAIR_W'(a_mat_reg.row1_col0) - mtq_pkg::PAIR_W'(a_mat_reg.row0_col1);
        end
        side_next.bad = (rad_s <= 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_rad_reg  <= rad_s[mtq_pkg::RAD_W-1:0];
        b_side_reg <= side_next;
    end

    assign out_valid = b_valid_reg;
    assign rad       = b_rad_reg;
    assign side      = b_side_reg;

endmodule

// ===== rtl/mtq_sqrt.sv =====
`timescale 1ns / 1ps

module mtq_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [mtq_pkg::RAD_W-1:0]     rad,
    input  mtq_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [mtq_pkg::ROOT_W-1:0]    root,
    output mtq_pkg::side_t                out_side
);

    localparam int N = mtq_pkg::SQ_STAGES;
    localparam int OP_W = 2 * mtq_pkg::ROOT_W;

    logic [N:0]                     v_reg;
    logic [OP_W-1:0]                op_reg   [0:N];
    logic [mtq_pkg::SQ_REM_W-1:0]   rem_reg  [0:N];
    logic [mtq_pkg::ROOT_W-1:0]     root_reg [0:N];
    mtq_pkg::side_t                 side_reg [0:N];

    assign v_reg[0]    = in_valid;
    assign op_reg[0]   = {rad, {(OP_W-mtq_pkg::RAD_W){1'b0}}};
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign side_reg[0] = in_side;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [mtq_pkg::SQ_REM_W-1:0] rem_sh;
        logic [mtq_pkg::SQ_REM_W-1:0] trial;
        logic                         take;

        assign rem_sh = {rem_reg[k][mtq_pkg::SQ_REM_W-3:0], op_reg[k][OP_W-1 -: 2]};
        assign trial  = {2'b00, root_reg[k], 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            op_reg[k+1]   <= {op_reg[k][OP_W-3:0], 2'b00};
            rem_reg[k+1]  <= take ? (rem_sh - trial) : rem_sh;
            root_reg[k+1] <= {root_reg[k][mtq_pkg::ROOT_W-2:0], take};
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = v_reg[N];
    assign root      = root_reg[N];
    assign out_side  = side_reg[N];

endmodule

// ===== rtl/mtq_div.sv =====
`timescale 1ns / 1ps

module mtq_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [mtq_pkg::DEN_W-1:0]     rem_init,
    input  logic [mtq_pkg::QUOT_W-1:0]    num_lo,
    input  logic [mtq_pkg::DEN_W-1:0]     den,
    input  mtq_pkg::dtag_t                in_tag,
    output logic [mtq_pkg::QUOT_W-1:0]    quot,
    output mtq_pkg::dtag_t                out_tag
);

    localparam int N = mtq_pkg::DIV_STAGES;

    logic [N:0]                      v_reg;
    logic [mtq_pkg::DIV_REM_W-1:0]   rem_reg  [0:N];
    logic [mtq_pkg::QUOT_W-1:0]      lo_reg   [0:N];
    logic [mtq_pkg::DEN_W-1:0]       den_reg  [0:N];
    logic [mtq_pkg::QUOT_W-1:0]      q_reg    [0:N];
    mtq_pkg::dtag_t                  tag_reg  [0:N];

    assign v_reg[0]   = in_valid;
    assign rem_reg[0] = {1'b0, rem_init};
    assign lo_reg[0]  = num_lo;
    assign den_reg[0] = den;
    assign q_reg[0]   = '0;
    assign tag_reg[0] = in_tag;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [mtq_pkg::DIV_REM_W-1:0] rem_sh;
        logic [mtq_pkg::DIV_REM_W-1:0] den_x;
        logic                          take;

        assign rem_sh = {rem_reg[k][mtq_pkg::DIV_REM_W-2:0], lo_reg[k][mtq_pkg::QUOT_W-1]};
        assign den_x  = {1'b0, den_reg[k]};
        assign take   = (rem_sh >= den_x);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= take ? (rem_sh - den_x) : rem_sh;
            lo_reg[k+1]  <= {lo_reg[k][mtq_pkg::QUOT_W-2:0], 1'b0};
            den_reg[k+1] <= den_reg[k];
            q_reg[k+1]   <= {q_reg[k][mtq_pkg::QUOT_W-2:0], take};
            tag_reg[k+1] <= tag_reg[k];
        end
    end

    assign quot    = q_reg[N];
    assign out_tag = tag_reg[N];

    property p_rem_below_den;
        @(posedge clk) disable iff (!rst_n)
        v_reg[N] && !tag_reg[N].ovf |-> (rem_reg[N] < {1'b0, den_reg[N]});
    endproperty
    a_rem_below_den: assert property (p_rem_below_den)
        else $error("divider remainder not below divisor");

endmodule
